### hw/rtl/mzfc_pkg.sv
// Shared types and constants of the multi-zone fan curve controller.
`default_nettype none

package mzfc_pkg;

   // Field widths
   localparam int TEMP_W     = 12;
   localparam int EXT_W      = TEMP_W + 2;
   localparam int DUTY_W     = 8;
   localparam int PCT_W      = 7;
   localparam int ZONE_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = TEMP_W;

   // Curve arithmetic: den = r*r, num = min*d*d
   localparam int DEN_W       = 2 * TEMP_W;
   localparam int NUM_W       = DEN_W + DUTY_W;
   localparam int PCT_NUM_W   = DUTY_W + PCT_W;
   localparam int CURVE_STEPS = DUTY_W;
   localparam int PCT_STEPS   = PCT_W;

   localparam logic [DUTY_W-1:0] DUTY_FULL   = 8'd255;
   localparam logic [DUTY_W-1:0] PCT_DIVISOR = 8'd255;
   localparam logic [PCT_W-1:0]  PCT_SCALE   = 7'd100;

   // Zone codes
   localparam logic [ZONE_W-1:0] ZONE_BOARD  = 3'd0;
   localparam logic [ZONE_W-1:0] ZONE_SUPPLY = 3'd1;
   localparam logic [ZONE_W-1:0] ZONE_ROOM   = 3'd2;
   localparam logic [ZONE_W-1:0] ZONE_PI     = 3'd3;
   localparam logic [ZONE_W-1:0] ZONE_AMP    = 3'd4;
   localparam logic [ZONE_W-1:0] ZONE_PC     = 3'd5;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HYSTERESIS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FAN_MIN_DUTY = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_MIN_DUTY = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOARD_HIGH   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SUPPLY_HIGH  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ROOM_HIGH    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_AMP_HIGH     = 3'd7;

   // Register reset values
   localparam logic [TEMP_W-1:0] THRESHOLD_RST   = 12'd350;
   localparam logic [DUTY_W-1:0] HYSTERESIS_RST  = 8'd20;
   localparam logic [DUTY_W-1:0] FAN_MIN_RST     = 8'd77;
   localparam logic [DUTY_W-1:0] TOP_MIN_RST     = 8'd77;
   localparam logic [TEMP_W-1:0] BOARD_HIGH_RST  = 12'd600;
   localparam logic [TEMP_W-1:0] SUPPLY_HIGH_RST = 12'd600;
   localparam logic [TEMP_W-1:0] ROOM_HIGH_RST   = 12'd400;
   localparam logic [TEMP_W-1:0] AMP_HIGH_RST    = 12'd600;

   typedef struct packed {
      logic [ZONE_W-1:0]        zone;
      logic signed [TEMP_W-1:0] temperature;
      logic                     fan_running;
      logic                     load_on;
   } req_payload_type;

   typedef struct packed {
      logic [ZONE_W-1:0]        zone_out;
      logic signed [TEMP_W-1:0] temperature_out;
      logic                     has_fan;
      logic [DUTY_W-1:0]        duty;
      logic [PCT_W-1:0]         percent;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MULT,
      ST_DIVIDE,
      ST_SUM,
      ST_PREP,
      ST_PERCENT,
      ST_DONE
   } fsm_state_type;

   typedef struct packed {
      logic start;
      logic pct_mode;
   } div_ctrl_type;

endpackage

`default_nettype wire

### hw/rtl/multi_zone_fan_curve_controller_core.sv
// Top level of the multi-zone fan curve controller.
`default_nettype none

// Channel   | Handshake            | Payload
// ----------+----------------------+-------------------------------------------
// request   | req_valid/req_stall  | req_data: zone, temperature, flags
// response  | rsp_valid/rsp_stall  | rsp_data: zone, temperature, duty, percent
// csr write | csr_valid/csr_ready  | csr_index, csr_wdata
//
// One request at a time. A request that needs the quadratic curve passes through
// the bit-serial multiplier (squaring, then scaling), the restoring divider, and
// the same divider again for the percent figure. Without the curve only the
// percent division runs; an unknown zone or an unchanged temperature is dropped
// without a response.
// Reset (synchronous) clears the zone temperatures to zero and loads register
// defaults. A stalled response waits in the output register while the next
// request is already being worked on.

module multi_zone_fan_curve_controller_core #(
   parameter int ZONES = 6
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  mzfc_pkg::req_payload_type       req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output mzfc_pkg::rsp_payload_type       rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mzfc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mzfc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mzfc_pkg::*;

   localparam int ZIDX_W = $clog2(ZONES);
   localparam logic [ZONE_W:0] ZONE_LIMIT = (ZONE_W + 1)'(ZONES);

   function automatic logic signed [EXT_W-1:0] ext_temp(input logic [TEMP_W-1:0] v);
      ext_temp = $signed({{(EXT_W - TEMP_W){v[TEMP_W-1]}}, v});
   endfunction

   // Control registers
   logic [TEMP_W-1:0] threshold_ff;
   logic [DUTY_W-1:0] hysteresis_ff;
   logic [DUTY_W-1:0] fan_min_duty_ff;
   logic [DUTY_W-1:0] top_fan_min_duty_ff;
   logic [TEMP_W-1:0] board_high_ff;
   logic [TEMP_W-1:0] supply_high_ff;
   logic [TEMP_W-1:0] room_high_ff;
   logic [TEMP_W-1:0] amp_high_ff;

   // Last temperature of each zone
   logic [TEMP_W-1:0] store_ff [ZONES];

   fsm_state_type     state_ff, state_in;
   req_payload_type   item_ff;
   logic              has_fan_ff;
   logic [DUTY_W-1:0] min_sel_ff;
   logic [DUTY_W-1:0] duty_ff;
   logic [PCT_W-1:0]  percent_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff;

   // Evaluation of the captured request
   logic                    zone_ok;
   logic                    same_temp;
   logic [ZIDX_W-1:0]       zone_idx;
   logic [TEMP_W-1:0]       high_sel;
   logic [DUTY_W-1:0]       min_sel;
   logic                    fan_sel;
   logic                    curve_sel;
   logic [DUTY_W-1:0]       fixed_duty;
   logic signed [EXT_W-1:0] t_x, thr_x, hys_x, lo_x, hi_x, high_x, d_x, r_x;
   logic                    below_band, in_band, at_thr, below_high;

   // Sequencer controls
   logic         item_load, eval_load, store_we, mult_start;
   logic         sum_load, pct_load, rsp_load, rsp_free;
   div_ctrl_type div_ctrl;

   // Arithmetic units
   logic [NUM_W-1:0]     mult_num;
   logic [DEN_W-1:0]     mult_den;
   logic                 mult_done;
   logic [NUM_W-1:0]     div_num;
   logic [DEN_W-1:0]     div_den;
   logic [DUTY_W-1:0]    div_quo;
   logic                 div_done;
   logic [PCT_NUM_W-1:0] pct_num;
   logic [DUTY_W:0]      duty_sum;

   // ---------------------------------------------------------------- decode
   assign zone_idx  = item_ff.zone[ZIDX_W-1:0];
   assign zone_ok   = ({1'b0, item_ff.zone} < ZONE_LIMIT);
   assign same_temp = (store_ff[zone_idx] == item_ff.temperature);

   // pick the zone's full-duty temperature and running minimum
   always_comb begin
      high_sel = board_high_ff;
      min_sel  = fan_min_duty_ff;
      unique case (item_ff.zone) inside
         ZONE_SUPPLY: high_sel = supply_high_ff;
         ZONE_ROOM: begin
            high_sel = room_high_ff;
            min_sel  = top_fan_min_duty_ff;
         end
         ZONE_AMP: high_sel = amp_high_ff;
         default:  high_sel = board_high_ff;
      endcase
   end

   assign t_x    = ext_temp(item_ff.temperature);
   assign thr_x  = ext_temp(threshold_ff);
   assign hys_x  = $signed({{(EXT_W - DUTY_W){1'b0}}, hysteresis_ff});
   assign lo_x   = thr_x - hys_x;
   assign hi_x   = thr_x + hys_x;
   assign high_x = ext_temp(high_sel);
   assign d_x    = t_x - thr_x;
   assign r_x    = high_x - thr_x;

   assign below_band = (t_x < lo_x);
   assign in_band    = (t_x <= hi_x);
   assign at_thr     = (t_x <= thr_x);
   assign below_high = (t_x < high_x);

   // branch of the fan curve; exact threshold falls low, exact high gives full
   always_comb begin
      fan_sel    = 1'b1;
      curve_sel  = 1'b0;
      fixed_duty = '0;
      unique case (item_ff.zone) inside
         ZONE_BOARD, ZONE_AMP: begin
            if (below_band) begin
               fixed_duty = '0;
            end else if (in_band) begin
               fixed_duty = item_ff.fan_running ? fan_min_duty_ff : '0;
            end else if (below_high) begin
               curve_sel = 1'b1;
            end else begin
               fixed_duty = DUTY_FULL;
            end
         end
         ZONE_SUPPLY: begin
            if (at_thr) begin
               fixed_duty = item_ff.load_on ? fan_min_duty_ff : '0;
            end else if (below_high) begin
               curve_sel = 1'b1;
            end else begin
               fixed_duty = DUTY_FULL;
            end
         end
         ZONE_ROOM: begin
            if (at_thr) begin
               fixed_duty = '0;
            end else if (below_high) begin
               curve_sel = 1'b1;
            end else begin
               fixed_duty = DUTY_FULL;
            end
         end
         ZONE_PI, ZONE_PC: fan_sel = 1'b0;
         default:          fan_sel = 1'b0;
      endcase
   end

   // ------------------------------------------------------------- sequencer
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (!zone_ok || same_temp) begin
               state_in = ST_IDLE;
            end else if (curve_sel) begin
               state_in = ST_MULT;
            end else begin
               state_in = ST_PREP;
            end
         end
         ST_MULT: begin
            if (mult_done) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM:  state_in = ST_PREP;
         ST_PREP: state_in = ST_PERCENT;
         ST_PERCENT: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall         = 1'b1;
      item_load         = 1'b0;
      eval_load         = 1'b0;
      store_we          = 1'b0;
      mult_start        = 1'b0;
      div_ctrl.start    = 1'b0;
      div_ctrl.pct_mode = 1'b0;
      sum_load          = 1'b0;
      pct_load          = 1'b0;
      rsp_load          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            item_load = 1'b1;
         end
         ST_EVAL: begin
            eval_load  = 1'b1;
            store_we   = zone_ok && !same_temp;
            mult_start = zone_ok && !same_temp && curve_sel;
         end
         ST_MULT:   div_ctrl.start = mult_done;
         ST_DIVIDE: ;
         ST_SUM:    sum_load = 1'b1;
         ST_PREP: begin
            div_ctrl.start    = 1'b1;
            div_ctrl.pct_mode = 1'b1;
         end
         ST_PERCENT: pct_load = div_done;
         ST_DONE:    rsp_load = rsp_free;
         default:    req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------ arithmetic
   mzfc_curve_mult u_mult (
      .clock       (clock),
      .reset       (reset),
      .start       (mult_start),
      .span_d      (d_x[TEMP_W-1:0]),
      .span_r      (r_x[TEMP_W-1:0]),
      .min_duty    (min_sel),
      .numerator   (mult_num),
      .denominator (mult_den),
      .done        (mult_done)
   );

   // percent = floor(duty * 100 / 255) through the same divider
   assign pct_num = PCT_NUM_W'(duty_ff) * PCT_NUM_W'(PCT_SCALE);
   assign div_num = div_ctrl.pct_mode ? NUM_W'(pct_num) : mult_num;
   assign div_den = div_ctrl.pct_mode ? DEN_W'(PCT_DIVISOR) : mult_den;

   mzfc_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .numerator (div_num),
      .divisor   (div_den),
      .quotient  (div_quo),
      .done      (div_done)
   );

   // min + quotient, saturated at full duty
   assign duty_sum = {1'b0, min_sel_ff} + {1'b0, div_quo};

   // ------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      if (item_load) begin
         item_ff <= req_data;
      end
      if (eval_load) begin
         has_fan_ff <= fan_sel;
         min_sel_ff <= min_sel;
         duty_ff    <= fixed_duty;
      end else if (sum_load) begin
         duty_ff <= duty_sum[DUTY_W] ? DUTY_FULL : duty_sum[DUTY_W-1:0];
      end
      if (pct_load) begin
         percent_ff <= div_quo[PCT_W-1:0];
      end
   end

   // hold the last temperature of each zone; reset to zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ZONES; i++) begin
            store_ff[i] <= '0;
         end
      end else if (store_we) begin
         store_ff[zone_idx] <= item_ff.temperature;
      end
   end

   // ------------------------------------------------------- response stage
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.zone_out        <= item_ff.zone;
         rsp_data_ff.temperature_out <= item_ff.temperature;
         rsp_data_ff.has_fan         <= has_fan_ff;
         rsp_data_ff.duty            <= duty_ff;
         rsp_data_ff.percent         <= percent_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------ register writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff        <= THRESHOLD_RST;
         hysteresis_ff       <= HYSTERESIS_RST;
         fan_min_duty_ff     <= FAN_MIN_RST;
         top_fan_min_duty_ff <= TOP_MIN_RST;
         board_high_ff       <= BOARD_HIGH_RST;
         supply_high_ff      <= SUPPLY_HIGH_RST;
         room_high_ff        <= ROOM_HIGH_RST;
         amp_high_ff         <= AMP_HIGH_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_THRESHOLD:    threshold_ff        <= csr_wdata;
            CSR_HYSTERESIS:   hysteresis_ff       <= csr_wdata[DUTY_W-1:0];
            CSR_FAN_MIN_DUTY: fan_min_duty_ff     <= csr_wdata[DUTY_W-1:0];
            CSR_TOP_MIN_DUTY: top_fan_min_duty_ff <= csr_wdata[DUTY_W-1:0];
            CSR_BOARD_HIGH:   board_high_ff       <= csr_wdata;
            CSR_SUPPLY_HIGH:  supply_high_ff      <= csr_wdata;
            CSR_ROOM_HIGH:    room_high_ff        <= csr_wdata;
            CSR_AMP_HIGH:     amp_high_ff         <= csr_wdata;
            default:          threshold_ff        <= threshold_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

### hw/rtl/mzfc_curve_mult.sv
// Bit-serial shift-add multiplier forming r*r and min*d*d for the fan curve.
`default_nettype none

module mzfc_curve_mult (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [mzfc_pkg::TEMP_W-1:0] span_d,
   input  logic [mzfc_pkg::TEMP_W-1:0] span_r,
   input  logic [mzfc_pkg::DUTY_W-1:0] min_duty,
   output logic [mzfc_pkg::NUM_W-1:0]  numerator,
   output logic [mzfc_pkg::DEN_W-1:0]  denominator,
   output logic                        done
);
   import mzfc_pkg::*;

   localparam int CNT_W = $clog2(TEMP_W);
   localparam logic [CNT_W-1:0] SQ_LAST = CNT_W'(TEMP_W - 1);
   localparam logic [CNT_W-1:0] SC_LAST = CNT_W'(DUTY_W - 1);

   logic              busy_ff,     busy_in;
   logic              scale_ff,    scale_in;
   logic              done_ff,     done_in;
   logic [CNT_W-1:0]  cnt_ff,      cnt_in;
   logic [DEN_W-1:0]  dd_mcand_ff, dd_mcand_in;
   logic [TEMP_W-1:0] dd_mplr_ff,  dd_mplr_in;
   logic [DEN_W-1:0]  dd_acc_ff,   dd_acc_in;
   logic [DEN_W-1:0]  rr_mcand_ff, rr_mcand_in;
   logic [TEMP_W-1:0] rr_mplr_ff,  rr_mplr_in;
   logic [DEN_W-1:0]  rr_acc_ff,   rr_acc_in;
   logic [NUM_W-1:0]  n_mcand_ff,  n_mcand_in;
   logic [DUTY_W-1:0] mn_mplr_ff,  mn_mplr_in;
   logic [NUM_W-1:0]  n_acc_ff,    n_acc_in;
   logic              last_step;

   always_comb begin
      busy_in     = busy_ff;
      scale_in    = scale_ff;
      done_in     = 1'b0;
      cnt_in      = cnt_ff;
      dd_mcand_in = dd_mcand_ff;
      dd_mplr_in  = dd_mplr_ff;
      dd_acc_in   = dd_acc_ff;
      rr_mcand_in = rr_mcand_ff;
      rr_mplr_in  = rr_mplr_ff;
      rr_acc_in   = rr_acc_ff;
      n_mcand_in  = n_mcand_ff;
      mn_mplr_in  = mn_mplr_ff;
      n_acc_in    = n_acc_ff;
      last_step   = (cnt_ff == '0);
      if (start) begin
         busy_in     = 1'b1;
         scale_in    = 1'b0;
         cnt_in      = SQ_LAST;
         dd_mcand_in = DEN_W'(span_d);
         dd_mplr_in  = span_d;
         dd_acc_in   = '0;
         rr_mcand_in = DEN_W'(span_r);
         rr_mplr_in  = span_r;
         rr_acc_in   = '0;
         mn_mplr_in  = min_duty;
      end else if (busy_ff && !scale_ff) begin
         // square both spans, one multiplier bit a cycle
         if (dd_mplr_ff[0]) begin
            dd_acc_in = dd_acc_ff + dd_mcand_ff;
         end
         if (rr_mplr_ff[0]) begin
            rr_acc_in = rr_acc_ff + rr_mcand_ff;
         end
         dd_mcand_in = dd_mcand_ff << 1;
         dd_mplr_in  = dd_mplr_ff >> 1;
         rr_mcand_in = rr_mcand_ff << 1;
         rr_mplr_in  = rr_mplr_ff >> 1;
         cnt_in      = cnt_ff - 1'b1;
         if (last_step) begin
            scale_in   = 1'b1;
            cnt_in     = SC_LAST;
            n_mcand_in = NUM_W'(dd_acc_in);
            n_acc_in   = '0;
         end
      end else if (busy_ff) begin
         // scale d*d by the minimum duty
         if (mn_mplr_ff[0]) begin
            n_acc_in = n_acc_ff + n_mcand_ff;
         end
         n_mcand_in = n_mcand_ff << 1;
         mn_mplr_in = mn_mplr_ff >> 1;
         cnt_in     = cnt_ff - 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         scale_ff <= 1'b0;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         scale_ff <= scale_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dd_mcand_ff <= dd_mcand_in;
      dd_mplr_ff  <= dd_mplr_in;
      dd_acc_ff   <= dd_acc_in;
      rr_mcand_ff <= rr_mcand_in;
      rr_mplr_ff  <= rr_mplr_in;
      rr_acc_ff   <= rr_acc_in;
      n_mcand_ff  <= n_mcand_in;
      mn_mplr_ff  <= mn_mplr_in;
      n_acc_ff    <= n_acc_in;
   end

   assign numerator   = n_acc_ff;
   assign denominator = rr_acc_ff;
   assign done        = done_ff;

endmodule

`default_nettype wire

### hw/rtl/mzfc_divider.sv
// Restoring divider, one quotient bit a cycle, shared by curve and percent.
`default_nettype none

module mzfc_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  mzfc_pkg::div_ctrl_type      ctrl,
   input  logic [mzfc_pkg::NUM_W-1:0]  numerator,
   input  logic [mzfc_pkg::DEN_W-1:0]  divisor,
   output logic [mzfc_pkg::DUTY_W-1:0] quotient,
   output logic                        done
);
   import mzfc_pkg::*;

   localparam int DVS_W = DEN_W + CURVE_STEPS - 1;
   localparam int CNT_W = $clog2(CURVE_STEPS);
   localparam logic [CNT_W-1:0] CURVE_LAST = CNT_W'(CURVE_STEPS - 1);
   localparam logic [CNT_W-1:0] PCT_LAST   = CNT_W'(PCT_STEPS - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff,  cnt_in;
   logic [NUM_W-1:0]  rem_ff,  rem_in;
   logic [DVS_W-1:0]  dvs_ff,  dvs_in;
   logic [DUTY_W-1:0] quo_ff,  quo_in;
   logic              fits;
   logic [NUM_W-1:0]  rem_diff;

   assign fits     = (rem_ff >= NUM_W'(dvs_ff));
   assign rem_diff = rem_ff - NUM_W'(dvs_ff);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         rem_in  = numerator;
         quo_in  = '0;
         if (ctrl.pct_mode) begin
            dvs_in = DVS_W'(divisor) << (PCT_STEPS - 1);
            cnt_in = PCT_LAST;
         end else begin
            dvs_in = DVS_W'(divisor) << (CURVE_STEPS - 1);
            cnt_in = CURVE_LAST;
         end
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_diff;
         end
         quo_in = {quo_ff[DUTY_W-2:0], fits};
         dvs_in = dvs_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire
